// ===== src/bfa_pkg.sv =====
// Shared types, constants and state codes of the best-fit free-list allocator.
package bfa_pkg;

	localparam int AW = 20;
	localparam int SW = AW + 1;
	localparam int GW = SW + 1;
	localparam int NEED_W = GW + 1;

	localparam int HEADER_BYTES = 8;
	localparam int NODE_BYTES = 24;
	localparam int MIN_GRANT = (NODE_BYTES > HEADER_BYTES) ?
		((NODE_BYTES - HEADER_BYTES + 3) / 4) * 4 : 0;
	localparam int RESET_REGION = 65536;
	localparam int ADDR_SPAN = 1 << AW;

	localparam logic [2:0] STATUS_OK = 3'd0;
	localparam logic [2:0] STATUS_ZERO = 3'd1;
	localparam logic [2:0] STATUS_NOFIT = 3'd2;
	localparam logic [2:0] STATUS_UNKNOWN = 3'd3;
	localparam logic [2:0] STATUS_FULL = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	localparam logic REG_REGION = 1'b0;
	localparam logic REG_POLICY = 1'b1;

	localparam logic [1:0] POLICY_BEST = 2'd1;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [SW-1:0] size;
	} seg_t;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [SW-1:0] bytes;
	} alloc_t;

	typedef struct packed {
		logic set;
		logic clr;
		logic clr_all;
	} alloc_ctl_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_A_SCAN,
		S_A_DEC,
		S_F_FIND,
		S_F_SEGS,
		S_F_DEC,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_INS,
		S_DONE
	} state_t;

endpackage

// ===== src/bfa_seg_mem.sv =====
// Free segment table memory with one write port and one registered read port.
module bfa_seg_mem
	import bfa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 16,
	parameter int SIW = 4
) (
	input  logic           clk,
	input  logic           we,
	input  logic [SIW-1:0] waddr,
	input  seg_t           wdata,
	input  logic [SIW-1:0] raddr,
	output seg_t           rdata
);

	seg_t mem [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/bfa_alloc_mem.sv =====
// Live allocation memory with per-entry valid flags and a free-slot encoder.
module bfa_alloc_mem
	import bfa_pkg::*;
#(
	parameter int MAX_ALLOCS = 32,
	parameter int AIW = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  alloc_ctl_t     ctl,
	input  logic [AIW-1:0] set_idx,
	input  alloc_t         set_data,
	input  logic [AIW-1:0] clr_idx,
	input  logic [AIW-1:0] raddr,
	output alloc_t         rdata,
	output logic           rvalid,
	output logic           any_free,
	output logic [AIW-1:0] free_idx
);

	alloc_t mem [MAX_ALLOCS];
	logic [MAX_ALLOCS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.set) begin
			mem[set_idx] <= set_data;
		end
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid <= 1'b0;
		end else begin
			rvalid <= valid_q[raddr];
			if (ctl.clr_all) begin
				valid_q <= '0;
			end else begin
				if (ctl.set) begin
					valid_q[set_idx] <= 1'b1;
				end
				if (ctl.clr) begin
					valid_q[clr_idx] <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = MAX_ALLOCS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = AIW'(i);
			end
		end
	end

endmodule

// ===== src/best_fit_free_list_allocator.sv =====
// Top level of the best-fit free-list allocator: handshake, sequencer and datapath.
//
// Each request is handled alone, one at a time, by a sequencer that walks the
// free segment table and the allocation table, both held in memories read one
// entry per cycle. An allocate runs a best-fit scan of the segment table,
// followed by a shift of the table tail when an exact fit removes a segment.
// A free first scans the allocation memory, then the segment table up to the
// insertion point, and then shifts the table tail by one entry per cycle when
// a segment is inserted or merged away. Results are held in an output
// register, so the next request is taken while a result waits. After reset
// an initialization state writes the first segment table entry before the
// first request is accepted.
module best_fit_free_list_allocator
	import bfa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 16,
	parameter int MAX_ALLOCS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          func,
	input  logic [SW-1:0] request_size,
	input  logic [AW-1:0] block_address,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    status,
	output logic [AW-1:0] payload_address,
	input  logic          cfg_write,
	input  logic          cfg_index,
	input  logic [SW-1:0] cfg_data
);

	localparam int SIW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int AIW = $clog2(MAX_ALLOCS);
	localparam int ACW = $clog2(MAX_ALLOCS + 1);

	localparam logic [SW-1:0] N_SW = SW'(NODE_BYTES);
	localparam logic [SW-1:0] H_SW = SW'(HEADER_BYTES);
	localparam logic [AW-1:0] H_AW = AW'(HEADER_BYTES);

	state_t state_q, state_d;

	logic [1:0]        policy_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     addr_q;
	logic [GW-1:0]     grant_q;
	logic [NEED_W-1:0] need_q;
	logic [CW-1:0]     issue_q;
	logic              pend_s1;
	logic [CW-1:0]     pidx_s1;
	logic              exact_q;
	logic              best_q;
	logic [SIW-1:0]    pick_q;
	logic [AW-1:0]     pick_start_q;
	logic [SW-1:0]     pick_size_q;
	logic [ACW-1:0]    a_issue_q;
	logic              a_pend_s1;
	logic [ACW-1:0]    a_pidx_s1;
	logic [AIW-1:0]    k_q;
	logic [AW-1:0]     s_q;
	logic [SW-1:0]     z_q;
	logic [CW-1:0]     p_q;
	logic              prev_ok_q;
	logic              pfound_q;
	seg_t              prev_q;
	seg_t              next_q;
	logic [2:0]        res_status_q;
	logic [AW-1:0]     res_addr_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [AW-1:0]     paddr_q;

	logic           seg_we;
	logic [SIW-1:0] seg_waddr;
	seg_t           seg_wdata;
	logic [SIW-1:0] seg_raddr;
	seg_t           seg_rd;

	alloc_ctl_t     al_ctl;
	logic [AIW-1:0] al_raddr;
	alloc_t         al_rd;
	logic           al_rvalid;
	logic           al_any_free;
	logic [AIW-1:0] al_free_idx;
	alloc_t         al_set_data;

	logic              in_acc;
	logic              out_free;
	logic              cfg_region;
	logic [SW-1:0]     cfg_span;
	logic [GW-1:0]     grant_rnd;
	logic [GW-1:0]     grant_in;
	logic [NEED_W-1:0] need_in;
	logic              policy_gate;
	logic              seg_issue;
	logic              up_issue;
	logic              a_issue_ok;
	logic [NEED_W-1:0] rd_size_ext;
	logic              exact_hit;
	logic              fit_hit;
	logic              a_ok;
	logic              free_hit;
	logic              above;
	logic [SW-1:0]     prev_end;
	logic [SW-1:0]     blk_end;
	logic              mp;
	logic              mn;
	logic              dec_full;

	bfa_seg_mem #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.SIW(SIW)
	) u_seg_mem (
		.clk(clk),
		.we(seg_we),
		.waddr(seg_waddr),
		.wdata(seg_wdata),
		.raddr(seg_raddr),
		.rdata(seg_rd)
	);

	bfa_alloc_mem #(
		.MAX_ALLOCS(MAX_ALLOCS),
		.AIW(AIW)
	) u_alloc_mem (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(al_ctl),
		.set_idx(al_free_idx),
		.set_data(al_set_data),
		.clr_idx(k_q),
		.raddr(al_raddr),
		.rdata(al_rd),
		.rvalid(al_rvalid),
		.any_free(al_any_free),
		.free_idx(al_free_idx)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign payload_address = paddr_q;

	assign cfg_region = cfg_write && (cfg_index == REG_REGION);
	assign cfg_span = (cfg_data > SW'(ADDR_SPAN)) ? SW'(ADDR_SPAN) : cfg_data;

	assign grant_rnd = ({1'b0, request_size} + GW'(3)) & ~GW'(3);
	assign grant_in = (grant_rnd < GW'(MIN_GRANT)) ? GW'(MIN_GRANT) : grant_rnd;
	assign need_in = NEED_W'(grant_in) + NEED_W'(HEADER_BYTES);
	assign policy_gate = (policy_q != POLICY_BEST) && (count_q != CW'(1));

	assign seg_issue = issue_q < count_q;
	assign up_issue = issue_q > p_q;
	assign a_issue_ok = a_issue_q < ACW'(MAX_ALLOCS);

	assign rd_size_ext = NEED_W'(seg_rd.size);
	assign exact_hit = pend_s1 && !exact_q && (rd_size_ext + NEED_W'(NODE_BYTES) == need_q);
	assign fit_hit = pend_s1 && !exact_q && (rd_size_ext >= need_q)
		&& (!best_q || (seg_rd.size < pick_size_q));
	assign a_ok = (exact_q || best_q) && al_any_free;
	assign al_set_data = '{start: pick_start_q + H_AW, bytes: grant_q[SW-1:0]};

	assign free_hit = a_pend_s1 && al_rvalid && (al_rd.start == addr_q);
	assign above = pend_s1 && (seg_rd.start > s_q);

	assign prev_end = {1'b0, prev_q.start} + N_SW + prev_q.size;
	assign blk_end = {1'b0, s_q} + N_SW + z_q;
	assign mp = prev_ok_q && (prev_end == {1'b0, s_q});
	assign mn = pfound_q && (blk_end == {1'b0, next_q.start});
	assign dec_full = !mp && !mn && (count_q >= CW'(MAX_SEGMENTS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					if (func == FUNC_FREE) begin
						state_d = S_F_FIND;
					end else if (request_size == '0 || policy_gate) begin
						state_d = S_DONE;
					end else begin
						state_d = S_A_SCAN;
					end
				end
			end
			S_A_SCAN: begin
				if (exact_hit || (!pend_s1 && !seg_issue)) begin
					state_d = S_A_DEC;
				end
			end
			S_A_DEC: begin
				state_d = (a_ok && exact_q) ? S_SHIFT_DN : S_DONE;
			end
			S_F_FIND: begin
				if (free_hit) begin
					state_d = S_F_SEGS;
				end else if (!a_pend_s1 && !a_issue_ok) begin
					state_d = S_DONE;
				end
			end
			S_F_SEGS: begin
				if (above || (!pend_s1 && !seg_issue)) begin
					state_d = S_F_DEC;
				end
			end
			S_F_DEC: begin
				if (mp && mn) begin
					state_d = S_SHIFT_DN;
				end else if (mp || mn || dec_full) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SHIFT_UP;
				end
			end
			S_SHIFT_DN: begin
				if (!pend_s1 && !seg_issue) begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_UP: begin
				if (!pend_s1 && !up_issue) begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_comb begin
		seg_we = 1'b0;
		seg_waddr = '0;
		seg_wdata = '0;
		seg_raddr = issue_q[SIW-1:0];
		al_raddr = a_issue_q[AIW-1:0];
		al_ctl = '0;
		case (state_q)
			S_INIT: begin
				seg_we = 1'b1;
				seg_wdata = '{start: '0, size: SW'(RESET_REGION - NODE_BYTES)};
			end
			S_A_DEC: begin
				al_ctl.set = a_ok;
				if (a_ok && !exact_q) begin
					seg_we = 1'b1;
					seg_waddr = pick_q;
					seg_wdata = '{start: pick_start_q + need_q[AW-1:0],
						size: pick_size_q - need_q[SW-1:0]};
				end
			end
			S_F_DEC: begin
				al_ctl.clr = !dec_full;
				if (mp) begin
					seg_we = 1'b1;
					seg_waddr = SIW'(p_q - CW'(1));
					seg_wdata = '{start: prev_q.start,
						size: prev_q.size + N_SW + z_q + (mn ? N_SW + next_q.size : '0)};
				end else if (mn) begin
					seg_we = 1'b1;
					seg_waddr = p_q[SIW-1:0];
					seg_wdata = '{start: s_q, size: next_q.size + N_SW + z_q};
				end
			end
			S_SHIFT_DN: begin
				seg_we = pend_s1;
				seg_waddr = SIW'(pidx_s1 - CW'(1));
				seg_wdata = seg_rd;
			end
			S_SHIFT_UP: begin
				seg_raddr = SIW'(issue_q - CW'(1));
				seg_we = pend_s1;
				seg_waddr = SIW'(pidx_s1 + CW'(1));
				seg_wdata = seg_rd;
			end
			S_INS: begin
				seg_we = 1'b1;
				seg_waddr = p_q[SIW-1:0];
				seg_wdata = '{start: s_q, size: z_q};
			end
			default: begin
			end
		endcase
		if (cfg_region) begin
			seg_we = 1'b1;
			seg_waddr = '0;
			seg_wdata = '{start: '0, size: cfg_span - N_SW};
			al_ctl.clr_all = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			policy_q <= POLICY_BEST;
			count_q <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_INIT: begin
					count_q <= CW'(1);
				end
				S_SHIFT_DN: begin
					if (!pend_s1 && !seg_issue) begin
						count_q <= count_q - CW'(1);
					end
				end
				S_INS: begin
					count_q <= count_q + CW'(1);
				end
				default: begin
				end
			endcase
			if (cfg_region) begin
				count_q <= (cfg_span >= N_SW) ? CW'(1) : '0;
			end
			if (cfg_write && cfg_index == REG_POLICY) begin
				policy_q <= cfg_data[1:0];
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			paddr_q <= res_addr_q;
		end
		case (state_q)
			S_IDLE: begin
				addr_q <= block_address;
				grant_q <= grant_in;
				need_q <= need_in;
				issue_q <= '0;
				pend_s1 <= 1'b0;
				exact_q <= 1'b0;
				best_q <= 1'b0;
				a_issue_q <= '0;
				a_pend_s1 <= 1'b0;
				res_addr_q <= '0;
				res_status_q <= (request_size == '0) ? STATUS_ZERO : STATUS_NOFIT;
			end
			S_A_SCAN: begin
				pend_s1 <= seg_issue;
				pidx_s1 <= issue_q;
				if (seg_issue) begin
					issue_q <= issue_q + CW'(1);
				end
				if (exact_hit) begin
					exact_q <= 1'b1;
				end else if (fit_hit) begin
					best_q <= 1'b1;
				end
				if (exact_hit || fit_hit) begin
					pick_q <= pidx_s1[SIW-1:0];
					pick_start_q <= seg_rd.start;
					pick_size_q <= seg_rd.size;
				end
			end
			S_A_DEC: begin
				if (a_ok) begin
					res_status_q <= STATUS_OK;
					res_addr_q <= pick_start_q + H_AW;
				end else if (exact_q || best_q) begin
					res_status_q <= STATUS_FULL;
				end else begin
					res_status_q <= STATUS_NOFIT;
				end
				issue_q <= CW'(pick_q) + CW'(1);
				pend_s1 <= 1'b0;
			end
			S_F_FIND: begin
				a_pend_s1 <= a_issue_ok;
				a_pidx_s1 <= a_issue_q;
				if (a_issue_ok) begin
					a_issue_q <= a_issue_q + ACW'(1);
				end
				res_status_q <= STATUS_UNKNOWN;
				if (free_hit) begin
					k_q <= a_pidx_s1[AIW-1:0];
					s_q <= addr_q - H_AW;
					z_q <= H_SW + al_rd.bytes - N_SW;
					issue_q <= '0;
					pend_s1 <= 1'b0;
					prev_ok_q <= 1'b0;
					pfound_q <= 1'b0;
					p_q <= count_q;
				end
			end
			S_F_SEGS: begin
				pend_s1 <= seg_issue;
				pidx_s1 <= issue_q;
				if (seg_issue) begin
					issue_q <= issue_q + CW'(1);
				end
				if (above) begin
					pfound_q <= 1'b1;
					p_q <= pidx_s1;
					next_q <= seg_rd;
				end else if (pend_s1) begin
					prev_ok_q <= 1'b1;
					prev_q <= seg_rd;
				end
			end
			S_F_DEC: begin
				res_status_q <= dec_full ? STATUS_FULL : STATUS_OK;
				pend_s1 <= 1'b0;
				issue_q <= (mp && mn) ? p_q + CW'(1) : count_q;
			end
			S_SHIFT_DN: begin
				pend_s1 <= seg_issue;
				pidx_s1 <= issue_q;
				if (seg_issue) begin
					issue_q <= issue_q + CW'(1);
				end
			end
			S_SHIFT_UP: begin
				pend_s1 <= up_issue;
				pidx_s1 <= issue_q - CW'(1);
				if (up_issue) begin
					issue_q <= issue_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/sv/best_fit_free_list_allocator_test.sv =====
// Self-checking testbench for the best-fit free-list allocator with a scoreboard class.
module best_fit_free_list_allocator_test;
	import bfa_pkg::*;

	localparam int NSEG = 16;
	localparam int NALLOC = 32;

	typedef struct {
		logic [2:0] status;
		logic [AW-1:0] addr;
	} reply_t;

	class heap_scoreboard;
		longint seg_lo[NSEG];
		longint seg_len[NSEG];
		int seg_n;
		longint blk_lo[NALLOC];
		longint blk_len[NALLOC];
		bit blk_live[NALLOC];
		longint region;
		int policy;
		reply_t pending[$];
		int errors;

		function void rebuild();
			longint span;
			span = region > ADDR_SPAN ? ADDR_SPAN : region;
			foreach (blk_live[i]) blk_live[i] = 0;
			foreach (seg_lo[i]) begin
				seg_lo[i] = 0;
				seg_len[i] = 0;
			end
			if (span >= NODE_BYTES) begin
				seg_n = 1;
				seg_len[0] = span - NODE_BYTES;
			end else begin
				seg_n = 0;
			end
		endfunction

		function void write_reg(logic idx, longint val);
			if (idx == REG_REGION) begin
				region = val & 21'h1FFFFF;
				rebuild();
			end else begin
				policy = val & 3;
			end
		endfunction

		function void drop_seg(int i);
			for (int j = i; j < seg_n - 1; j++) begin
				seg_lo[j] = seg_lo[j + 1];
				seg_len[j] = seg_len[j + 1];
			end
			seg_n--;
		endfunction

		function logic [2:0] grant(longint req, output longint addr);
			longint g, need;
			int pick, slot;
			bit exact;
			addr = 0;
			pick = seg_n;
			slot = NALLOC;
			exact = 0;
			if (req == 0) return STATUS_ZERO;
			g = (req + 3) & ~longint'(3);
			if (g < MIN_GRANT) g = MIN_GRANT;
			need = HEADER_BYTES + g;
			if (policy != POLICY_BEST && seg_n != 1) return STATUS_NOFIT;
			for (int i = 0; i < seg_n; i++)
				if (seg_len[i] + NODE_BYTES == need) begin
					pick = i;
					exact = 1;
					break;
				end
			if (!exact)
				for (int i = 0; i < seg_n; i++)
					if (seg_len[i] >= need && (pick == seg_n || seg_len[i] < seg_len[pick]))
						pick = i;
			if (pick >= seg_n) return STATUS_NOFIT;
			for (int i = 0; i < NALLOC; i++)
				if (!blk_live[i]) begin
					slot = i;
					break;
				end
			if (slot >= NALLOC) return STATUS_FULL;
			addr = seg_lo[pick] + HEADER_BYTES;
			if (exact) begin
				drop_seg(pick);
			end else begin
				seg_lo[pick] += need;
				seg_len[pick] -= need;
			end
			blk_live[slot] = 1;
			blk_lo[slot] = addr;
			blk_len[slot] = g;
			return STATUS_OK;
		endfunction

		function logic [2:0] release_blk(longint a);
			int k, p;
			longint s, z;
			bit mp, mn;
			k = NALLOC;
			for (int i = 0; i < NALLOC; i++)
				if (blk_live[i] && blk_lo[i] == a) begin
					k = i;
					break;
				end
			if (k >= NALLOC) return STATUS_UNKNOWN;
			s = a - HEADER_BYTES;
			z = HEADER_BYTES + blk_len[k] - NODE_BYTES;
			p = seg_n;
			for (int i = 0; i < seg_n; i++)
				if (seg_lo[i] > s) begin
					p = i;
					break;
				end
			mp = p > 0 && seg_lo[p - 1] + NODE_BYTES + seg_len[p - 1] == s;
			mn = p < seg_n && s + NODE_BYTES + z == seg_lo[p];
			if (mp && mn) begin
				seg_len[p - 1] += 2 * NODE_BYTES + z + seg_len[p];
				drop_seg(p);
			end else if (mp) begin
				seg_len[p - 1] += NODE_BYTES + z;
			end else if (mn) begin
				seg_len[p] += NODE_BYTES + z;
				seg_lo[p] = s;
			end else begin
				if (seg_n >= NSEG) return STATUS_FULL;
				for (int j = seg_n; j > p; j--) begin
					seg_lo[j] = seg_lo[j - 1];
					seg_len[j] = seg_len[j - 1];
				end
				seg_lo[p] = s;
				seg_len[p] = z;
				seg_n++;
			end
			blk_live[k] = 0;
			return STATUS_OK;
		endfunction

		function void note_request(logic f, longint req, longint a);
			reply_t r;
			longint addr;
			if (f == FUNC_ALLOC) r.status = grant(req, addr);
			else r.status = release_blk(a);
			if (r.status != STATUS_OK) addr = 0;
			r.addr = addr[AW-1:0];
			pending.push_back(r);
		endfunction

		function void check_reply(logic [2:0] st, logic [AW-1:0] addr);
			reply_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status %0d address %0h", $time, st, addr);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (addr !== e.addr) begin
				$display("%0t: address expected %0h actual %0h", $time, e.addr, addr);
				errors++;
			end
		endfunction

		function int live_count();
			int n;
			n = 0;
			foreach (blk_live[i]) n += blk_live[i];
			return n;
		endfunction

		function longint pick_live();
			int i;
			do i = $urandom_range(NALLOC - 1); while (!blk_live[i]);
			return blk_lo[i];
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic func = 0;
	logic [SW-1:0] request_size = 0;
	logic [AW-1:0] block_address = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [AW-1:0] payload_address;
	logic cfg_write = 0;
	logic cfg_index = 0;
	logic [SW-1:0] cfg_data = 0;
	bit sink_busy = 0;

	heap_scoreboard sb;

	best_fit_free_list_allocator dut (.*);

	always #2 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(3);
		return $urandom_range(60, 10);
	endfunction

	task automatic send(logic f, longint req, longint a);
		int g;
		func <= f;
		request_size <= req[SW-1:0];
		block_address <= a[AW-1:0];
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_request(f, req, a);
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic set_reg(logic idx, longint val);
		drain();
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val[SW-1:0];
		@(negedge clk);
		cfg_write <= 0;
		sb.write_reg(idx, val);
	endtask

	function automatic longint rand_size();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(200, 1);
		if (r < 90) return $urandom_range(4000, 1);
		if (r < 97) return $urandom_range(20'hFFFFF, 1);
		return $urandom_range(21'h1FFFFF);
	endfunction

	task automatic random_phase(int n);
		longint a;
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(99);
			if (r < 50) begin
				send(FUNC_ALLOC, rand_size(), $urandom);
			end else if (r < 90 && sb.live_count() > 0) begin
				send(FUNC_FREE, $urandom, sb.pick_live());
			end else begin
				a = $urandom_range(20'hFFFFF);
				send(FUNC_FREE, $urandom, $urandom_range(1) ? a : (a & ~20'h7));
			end
			if (i == n / 2) drain();
		end
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) sb.check_reply(status, payload_address);

	always @(negedge clk) begin
		int g;
		if (sink_busy) begin
			g = gap_len();
			out_stall <= g > 1;
			if (g > 1) sink_busy <= 0;
		end else begin
			out_stall <= $urandom_range(99) < 12;
			sink_busy <= $urandom_range(99) < 20;
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		sb = new();
		sb.region = RESET_REGION;
		sb.policy = POLICY_BEST;
		sb.errors = 0;
		sb.rebuild();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		send(FUNC_ALLOC, 0, 0);
		send(FUNC_ALLOC, 1, 0);
		send(FUNC_ALLOC, 17, 0);
		send(FUNC_ALLOC, 21'h1FFFFF, 0);
		send(FUNC_ALLOC, 21'h100000, 0);
		send(FUNC_FREE, 0, 8);
		send(FUNC_FREE, 0, 20'hFFFFF);
		send(FUNC_FREE, 0, 8);
		send(FUNC_FREE, 0, 32);
		send(FUNC_ALLOC, 16, 21'h1FFFFF);
		send(FUNC_ALLOC, 65496, 0);
		send(FUNC_ALLOC, 4, 0);

		set_reg(REG_REGION, 300);
		for (int i = 0; i < 12; i++) send(FUNC_ALLOC, 16, 0);
		for (int i = 0; i < 12; i += 2) send(FUNC_FREE, 0, sb.pick_live());
		send(FUNC_ALLOC, 500, 0);

		set_reg(REG_REGION, 20);
		send(FUNC_ALLOC, 4, 0);
		set_reg(REG_REGION, 21'h1FFFFF);
		send(FUNC_ALLOC, 21'h0FFFF0, 0);
		set_reg(REG_POLICY, 0);
		send(FUNC_ALLOC, 8, 0);
		send(FUNC_ALLOC, 8, 0);

		set_reg(REG_REGION, 32);
		set_reg(REG_POLICY, 3);
		send(FUNC_ALLOC, 4, 0);
		set_reg(REG_POLICY, 1);

		set_reg(REG_REGION, 2048);
		random_phase(180);
		set_reg(REG_REGION, 1200);
		random_phase(160);
		set_reg(REG_POLICY, 2);
		random_phase(60);
		set_reg(REG_POLICY, 1);
		set_reg(REG_REGION, 1048576);
		random_phase(120);
		set_reg(REG_REGION, 500);
		random_phase(120);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ===== files.f =====
src/bfa_pkg.sv
src/bfa_seg_mem.sv
src/bfa_alloc_mem.sv
src/best_fit_free_list_allocator.sv
tb/sv/best_fit_free_list_allocator_test.sv
